/* rtl/dmrc_pkg.sv */
package dmrc_pkg;

    localparam int unsigned LINE_BITS = 64;
    localparam int unsigned REQ_W     = 42;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    localparam logic OP_READ = 1'b0;
    localparam logic OP_FILL = 1'b1;

endpackage

/* rtl/direct_mapped_read_cache_extract.sv */
// Direct-mapped read cache with little-endian field extraction. A read item (opcode 0) gives a
// byte-aligned bit offset and a bit count (8..64); whole bytes are assembled from one line, or
// from two neighbouring lines when the field crosses a line boundary. Each line looked up counts
// as a hit or a miss; every missed line produces a fill request item and the read stays pending
// until fill items (opcode 1) deliver all missing lines, then the value item follows. A
// misaligned offset, bad count, read while pending or unrequested fill gives an error item.
// Tags and data live in synchronous memories with per-entry valid flops cleared at reset. An
// input item passes through these states from its acceptance to the next one: S_LOOK reads the
// two addressed entries of each memory, S_DECIDE compares and decides, S_OUT1 and S_OUT2 offer
// one result item each at the output register (none for a fill that still leaves a line awaited,
// one or two otherwise), and S_IDLE takes the next item. Output stalls hold a result item at the
// output register until it is taken. One item is in flight at a time.
module direct_mapped_read_cache_extract
    import dmrc_pkg::*;
#(
    parameter int unsigned ENTRIES     = 64,
    parameter int unsigned OFFSET_BITS = 48
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [OFFSET_BITS-1:0] bit_offset,
    input  logic [6:0]             bit_count,
    input  logic [REQ_W-1:0]       fill_line,
    input  logic [63:0]            fill_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             kind,
    output logic [63:0]            value,
    output logic [REQ_W-1:0]       request_line,
    output logic                   first_line_hit,
    output logic                   second_line_hit,
    output logic                   spans_two_lines,
    output logic [63:0]            hit_total,
    output logic [63:0]            miss_total,
    output logic                   last
);

    localparam int unsigned IDX_W  = $clog2(ENTRIES);
    localparam int unsigned LINE_W = OFFSET_BITS - 6;
    localparam int unsigned TAG_W  = (LINE_W - IDX_W) > 0 ? (LINE_W - IDX_W) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_OUT1, S_OUT2
    } state_t;

    state_t state_reg;

    // memories: two read ports (entries of first and second line), one write port
    logic [TAG_W-1:0] tag_mem  [ENTRIES];
    logic [63:0]      data_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [TAG_W-1:0] tag0_reg, tag1_reg;
    logic [63:0]      data0_reg, data1_reg;
    logic             v0_reg, v1_reg;

    // captured item
    logic                   op_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [6:0]             cnt_reg;
    logic [REQ_W-1:0]       fline_reg;
    logic [63:0]            fdata_reg;

    // pending read
    logic                   pend_reg;
    logic [OFFSET_BITS-1:0] poff_reg;
    logic [6:0]             pcnt_reg;
    logic [1:0]             await_reg;
    logic [1:0]             phits_reg;

    logic [63:0] hit_reg, miss_reg;

    // second result item held for S_OUT2
    logic [REQ_W-1:0] req2_reg;

    logic [1:0]       kind_reg;
    logic [63:0]      value_reg;
    logic [REQ_W-1:0] reqline_reg;
    logic             h0o_reg, h1o_reg, spo_reg, last_reg;

    // line addresses of the item under work (read: own offset, fill: pending offset)
    logic [OFFSET_BITS-1:0] eff_off;
    logic [6:0]             eff_cnt;
    logic [LINE_W-1:0]      l0, l1;
    logic                   spans;
    logic [IDX_W-1:0]       i0, i1;

    assign eff_off = (op_reg == OP_READ) ? off_reg : poff_reg;
    assign eff_cnt = (op_reg == OP_READ) ? cnt_reg : pcnt_reg;
    assign l0      = eff_off[OFFSET_BITS-1:6];
    assign l1      = l0 + LINE_W'(1);
    assign i0      = l0[IDX_W-1:0];
    assign i1      = l1[IDX_W-1:0];
    assign spans   = ({1'b0, eff_off[5:0]} + eff_cnt - 7'd1) >= 7'd64;

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        tag0_reg  <= tag_mem[i0];
        tag1_reg  <= tag_mem[i1];
        data0_reg <= data_mem[i0];
        data1_reg <= data_mem[i1];
    end

    logic          hit0, hit1, bad_read;
    logic [127:0]  pair;
    logic [63:0]   asm_val, mask;
    logic [2:0]    nb;
    logic          match0, match1;

    assign hit0 = v0_reg && (tag0_reg == TAG_W'(l0 >> IDX_W));
    assign hit1 = v1_reg && (tag1_reg == TAG_W'(l1 >> IDX_W));
    assign bad_read = pend_reg || (off_reg[2:0] != 3'd0) || (cnt_reg < 7'd8)
                      || (cnt_reg > 7'd64);
    assign match0 = pend_reg && await_reg[0] && (fline_reg == REQ_W'(l0));
    assign match1 = pend_reg && await_reg[1] && (fline_reg == REQ_W'(l1));

    // assembly from the two read lines; a fill supplies fresh data for its own line
    logic [63:0] d0, d1;
    always_comb
    begin
        d0 = data0_reg;
        d1 = data1_reg;
        if (op_reg == OP_FILL)
        begin
            if (match0 || i0 == i1 && match1)
                d0 = fdata_reg;
            if (match1 || i0 == i1 && match0)
                d1 = fdata_reg;
        end
        pair    = {d1, d0} >> {eff_off[5:3], 3'b000};
        nb      = eff_cnt[5:3];
        mask    = eff_cnt[6] ? '1 : ((64'd1 << {nb, 3'b000}) - 64'd1);
        asm_val = pair[63:0] & mask;
    end

    assign in_ready = (state_reg == S_IDLE);

    logic [1:0] await_new;
    assign await_new = await_reg & ~{match1 & ~match0, match0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            poff_reg  <= '0;
            pcnt_reg  <= '0;
            await_reg <= '0;
            phits_reg <= '0;
            hit_reg   <= '0;
            miss_reg  <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    v0_reg    <= valid_reg[i0];
                    v1_reg    <= valid_reg[i1];
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT1;
                    if (op_reg == OP_READ)
                    begin
                        if (!bad_read)
                        begin
                            hit_reg  <= hit_reg + 64'(hit0) + 64'(spans && hit1);
                            miss_reg <= miss_reg + 64'(!hit0) + 64'(spans && !hit1);
                            if (!(hit0 && (!spans || hit1)))
                            begin
                                pend_reg  <= 1'b1;
                                poff_reg  <= off_reg;
                                pcnt_reg  <= cnt_reg;
                                phits_reg <= {spans & hit1, hit0};
                                await_reg <= {spans & !hit1, !hit0};
                            end
                        end
                    end
                    else if (match0 || match1)
                    begin
                        valid_reg[match0 ? i0 : i1] <= 1'b1;
                        await_reg <= await_new;
                        if (await_new == 2'b00)
                            pend_reg <= 1'b0;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_OUT1:
                begin
                    if (out_ready)
                        state_reg <= last_reg ? S_IDLE : S_OUT2;
                end
                S_OUT2:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers and memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg    <= opcode;
            off_reg   <= bit_offset;
            cnt_reg   <= bit_count;
            fline_reg <= fill_line;
            fdata_reg <= fill_data;
        end
        if (state_reg == S_DECIDE)
        begin
            value_reg   <= '0;
            reqline_reg <= '0;
            h0o_reg     <= 1'b0;
            h1o_reg     <= 1'b0;
            spo_reg     <= 1'b0;
            last_reg    <= 1'b1;
            kind_reg    <= KIND_ERROR;
            req2_reg    <= REQ_W'(l1);
            if (op_reg == OP_READ)
            begin
                if (!bad_read)
                begin
                    h0o_reg <= hit0;
                    h1o_reg <= spans & hit1;
                    spo_reg <= spans;
                    if (hit0 && (!spans || hit1))
                    begin
                        kind_reg  <= KIND_VALUE;
                        value_reg <= asm_val;
                    end
                    else
                    begin
                        kind_reg    <= KIND_REQUEST;
                        reqline_reg <= hit0 ? REQ_W'(l1) : REQ_W'(l0);
                        last_reg    <= !((!hit0) && spans && !hit1);
                    end
                end
            end
            else if (match0 || match1)
            begin
                tag_mem[match0 ? i0 : i1]  <= match0 ? TAG_W'(l0 >> IDX_W)
                                                     : TAG_W'(l1 >> IDX_W);
                data_mem[match0 ? i0 : i1] <= fdata_reg;
                kind_reg  <= KIND_VALUE;
                value_reg <= asm_val;
                h0o_reg   <= phits_reg[0];
                h1o_reg   <= phits_reg[1];
                spo_reg   <= spans;
            end
        end
        else if (state_reg == S_OUT1 && out_ready && !last_reg)
        begin
            reqline_reg <= req2_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid       = (state_reg == S_OUT1) || (state_reg == S_OUT2);
    assign kind            = kind_reg;
    assign value           = value_reg;
    assign request_line    = reqline_reg;
    assign first_line_hit  = h0o_reg;
    assign second_line_hit = h1o_reg;
    assign spans_two_lines = spo_reg;
    assign hit_total       = hit_reg;
    assign miss_total      = miss_reg;
    assign last            = last_reg;

endmodule
